// ===== src/toy_isa_execute_unit_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef TOY_ISA_EXECUTE_UNIT_DEFINES_SVH
`define TOY_ISA_EXECUTE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TIE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define TIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tie_pkg.sv =====
`default_nettype none
package tie_pkg;

  localparam int DATA_WORDS_DEF  = 1024;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int REG_COUNT       = 8;
  localparam int REG_IDX_W       = 3;
  localparam logic [15:0] START_PC_RST = 16'd10;

  // Item kinds
  localparam logic [1:0] KIND_EXEC   = 2'd0;
  localparam logic [1:0] KIND_WR_MEM = 2'd1;
  localparam logic [1:0] KIND_WR_REG = 2'd2;
  localparam logic [1:0] KIND_RD_REG = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;
  localparam logic [1:0] ERR_DIV0  = 2'd3;

  // Opcodes
  localparam logic [7:0] OP_LD   = 8'h40;
  localparam logic [7:0] OP_ST   = 8'h41;
  localparam logic [7:0] OP_ADD  = 8'h50;
  localparam logic [7:0] OP_SUB  = 8'h51;
  localparam logic [7:0] OP_MUL  = 8'h52;
  localparam logic [7:0] OP_DIV  = 8'h53;
  localparam logic [7:0] OP_MOD  = 8'h54;
  localparam logic [7:0] OP_PUSH = 8'h60;
  localparam logic [7:0] OP_POP  = 8'h61;
  localparam logic [7:0] OP_LEA  = 8'h70;
  localparam logic [7:0] OP_JMP  = 8'h80;
  localparam logic [7:0] OP_JNE  = 8'h81;
  localparam logic [7:0] OP_JE   = 8'h82;
  localparam logic [7:0] OP_JB   = 8'h83;
  localparam logic [7:0] OP_JA   = 8'h84;
  localparam logic [7:0] OP_CMP  = 8'h90;

  // Multiply/divide unit control
  typedef struct packed {
    logic go;
    logic mul;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic ov;
  } md_rsp_t;

endpackage
`default_nettype wire

// ===== src/tie_rstmem.sv =====
`default_nettype none
// Small synchronous memory, one write and one registered read port.
// Entries never written since reset read as zero.
module tie_rstmem #(
  parameter int DEPTH = tie_pkg::REG_COUNT
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [31:0]              wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [31:0]              rdata
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [31:0]      rdata_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/tie_dmem.sv =====
`default_nettype none
// Data store: one write port, one registered read port, no reset.
module tie_dmem #(
  parameter int DATA_WORDS = tie_pkg::DATA_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DATA_WORDS)-1:0] waddr,
  input  wire logic [31:0]                   wdata,
  input  wire logic [$clog2(DATA_WORDS)-1:0] raddr,
  output logic      [31:0]                   rdata
);

  logic [31:0] mem [DATA_WORDS];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/tie_muldiv.sv =====
`default_nettype none
// Bit-serial multiply (shift and add) and restoring divide, 32 steps each.
// Multiply: x = product, ov = carry out of any accumulate step.
// Divide:   z = quotient, x = remainder.
module tie_muldiv (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tie_pkg::md_req_t req,
  input  wire logic [31:0]     op_a,
  input  wire logic [31:0]     op_b,
  output tie_pkg::md_rsp_t     rsp,
  output logic      [31:0]     res_x,
  output logic      [31:0]     res_z
);

  logic        busy_r;
  logic        done_r;
  logic        mul_r;
  logic        ov_r;
  logic [4:0]  cnt_r;
  logic [31:0] x_r;
  logic [31:0] y_r;
  logic [31:0] z_r;

  logic [31:0] x_nxt;
  logic [31:0] y_nxt;
  logic [31:0] z_nxt;
  logic        ov_nxt;
  logic [32:0] sum;
  logic [32:0] shifted;
  logic [33:0] diff;

  // one step of the selected operation
  always_comb begin
    sum     = {1'b0, x_r} + {1'b0, y_r};
    shifted = {x_r, z_r[31]};
    diff    = {1'b0, shifted} - {2'b00, y_r};
    if (mul_r) begin
      x_nxt  = z_r[0] ? sum[31:0] : x_r;
      ov_nxt = ov_r | (z_r[0] & sum[32]);
      y_nxt  = {y_r[30:0], 1'b0};
      z_nxt  = {1'b0, z_r[31:1]};
    end else begin
      x_nxt  = diff[33] ? shifted[31:0] : diff[31:0];
      ov_nxt = 1'b0;
      y_nxt  = y_r;
      z_nxt  = {z_r[30:0], ~diff[33]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mul_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mul_r  <= req.mul;
        ov_r   <= 1'b0;
      end else if (busy_r) begin
        ov_r  <= ov_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      x_r <= '0;
      y_r <= req.mul ? op_a : op_b;
      z_r <= req.mul ? op_b : op_a;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.ov   = ov_r;
  assign res_x    = x_r;
  assign res_z    = z_r;

`include "toy_isa_execute_unit_defines.svh"

  `TIE_ASSERT_IMP(a_done_one_shot, done_r, !busy_r, "done while still busy")
  `TIE_ASSERT_NEXT(a_go_busy, req.go, busy_r, "go did not start the unit")
  `TIE_ASSERT_NEXT(a_done_pulse, done_r, !done_r || req.go, "done held longer than one cycle")

endmodule
`default_nettype wire

// ===== src/toy_isa_execute_unit.sv =====
`default_nettype none
// Channel   Handshake             Payload
// input     start / busy          in_kind, in_instruction, in_address, in_value
// result    out_strobe (1 cycle)  out_next_pc, out_read_data, out_*_flag, out_error_code
// config    cfg_we                cfg_wdata (start PC, also loads the PC)
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result strobe, and the next item can be taken at the end of that
// cycle. Host items pass S_HOST; EXEC items read operands and run S_EXEC, where
// LD, ST and LEA (more with a scale) add address and memory states; MUL, and
// DIV/MOD with a nonzero divisor, wait for the 32-step serial multiply/divide
// unit; all then pass S_FIN and S_OUT. Each data address reduction adds S_AMWT
// when DATA_WORDS is not a power of two (reciprocal multiply, then subtract).
// Reset (rst_n low, synchronous) clears registers, stack, flags and loads PC 10.
// The result is shown for one cycle only; the receiver cannot stall it.
module toy_isa_execute_unit #(
  parameter int DATA_WORDS  = tie_pkg::DATA_WORDS_DEF,
  parameter int STACK_DEPTH = tie_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_instruction,
  input  wire logic [9:0]  in_address,
  input  wire logic [31:0] in_value,
  output logic             out_strobe,
  output logic      [15:0] out_next_pc,
  output logic      [31:0] out_read_data,
  output logic             out_zero_flag,
  output logic             out_sign_flag,
  output logic             out_overflow_flag,
  output logic      [1:0]  out_error_code,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int  AW   = $clog2(DATA_WORDS);
  localparam int  SIW  = $clog2(STACK_DEPTH);
  localparam int  CW   = $clog2(STACK_DEPTH + 1);
  localparam bit  POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
  localparam int  RW   = tie_pkg::REG_IDX_W;
  // reciprocal of DATA_WORDS for the address reduction
  localparam int          ASH  = 32 + AW;
  localparam logic [32:0] AREC = 33'((64'd1 << ASH) / 64'(DATA_WORDS) + 64'd1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HOST  = 5'd1;
  localparam logic [4:0] S_RDA   = 5'd2;
  localparam logic [4:0] S_RDB   = 5'd3;
  localparam logic [4:0] S_EXEC  = 5'd4;
  localparam logic [4:0] S_MDWT  = 5'd5;
  localparam logic [4:0] S_ADDR  = 5'd6;
  localparam logic [4:0] S_AMWT  = 5'd7;
  localparam logic [4:0] S_LDRD  = 5'd8;
  localparam logic [4:0] S_LDW   = 5'd9;
  localparam logic [4:0] S_STWR  = 5'd10;
  localparam logic [4:0] S_POPW  = 5'd11;
  localparam logic [4:0] S_LEA0  = 5'd12;
  localparam logic [4:0] S_LEA1  = 5'd13;
  localparam logic [4:0] S_LEA2  = 5'd14;
  localparam logic [4:0] S_LEA3  = 5'd15;
  localparam logic [4:0] S_LEA3R = 5'd16;
  localparam logic [4:0] S_LEA4  = 5'd17;
  localparam logic [4:0] S_LEA5  = 5'd18;
  localparam logic [4:0] S_H1WR  = 5'd19;
  localparam logic [4:0] S_FIN   = 5'd20;
  localparam logic [4:0] S_OUT   = 5'd21;

  // control and datapath registers
  logic [4:0]    state_r, state_nxt;
  logic [4:0]    ret_r, ret_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   ins_r, ins_nxt;
  logic [9:0]    adr_r, adr_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [31:0]   a_r, a_nxt;
  logic [31:0]   b_r, b_nxt;
  logic [31:0]   araw_r, araw_nxt;
  logic [64:0]   arec_r, arec_nxt;
  logic [AW-1:0] aidx_r, aidx_nxt;
  logic [31:0]   t_r, t_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   pc_r, pc_nxt;
  logic          zf_r, zf_nxt;
  logic          sf_r, sf_nxt;
  logic          of_r, of_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          ostb_r, ostb_nxt;
  logic [15:0]   opc_r, opc_nxt;
  logic [31:0]   ord_r, ord_nxt;
  logic          oz_r, oz_nxt;
  logic          os_r, os_nxt;
  logic          oo_r, oo_nxt;
  logic [1:0]    oe_r, oe_nxt;

  // memory ports
  logic          rf_we;
  logic [RW-1:0] rf_wa;
  logic [31:0]   rf_wd;
  logic [RW-1:0] rf_ra;
  logic [31:0]   rf_rdata;
  logic          dm_we;
  logic [31:0]   dm_wd;
  logic [AW-1:0] dm_ra;
  logic [31:0]   dm_rdata;
  logic          st_we;
  logic [SIW-1:0] st_wa;
  logic [31:0]   st_wd;
  logic [SIW-1:0] st_ra;
  logic [31:0]   st_rdata;

  tie_pkg::md_req_t md_req;
  tie_pkg::md_rsp_t md_rsp;
  logic [31:0]      md_a;
  logic [31:0]      md_b;
  logic [31:0]      md_x;
  logic [31:0]      md_z;

  // instruction fields
  logic [7:0]    op;
  logic [RW-1:0] dsel;
  logic [7:0]    s1f;
  logic [7:0]    s2f;
  logic [CW-1:0] cnt_dec;
  logic [32:0]   add_w;
  logic          lt_w;
  logic [31:0]   md_res;
  logic          taken;
  logic [31:0]   aquo_w;
  logic [31:0]   arem_w;

  assign op      = ins_r[31:24];
  assign dsel    = ins_r[16 +: RW];
  assign s1f     = ins_r[15:8];
  assign s2f     = ins_r[7:0];
  assign cnt_dec = cnt_r - CW'(1);
  assign add_w   = {1'b0, a_r} + {1'b0, rf_rdata};
  assign lt_w    = a_r < rf_rdata;
  assign md_res  = (op == tie_pkg::OP_MUL) ? md_x :
                   (op == tie_pkg::OP_DIV) ? md_z : md_x;

  // address remainder from the registered reciprocal product
  assign aquo_w = 32'(arec_r >> ASH);
  assign arem_w = araw_r - aquo_w * 32'(DATA_WORDS);

  // jump decision from current flags
  always_comb begin
    unique case (op)
      tie_pkg::OP_JMP: taken = 1'b1;
      tie_pkg::OP_JNE: taken = !zf_r;
      tie_pkg::OP_JE:  taken = zf_r;
      tie_pkg::OP_JB:  taken = sf_r;
      tie_pkg::OP_JA:  taken = !sf_r && !zf_r;
      default:         taken = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    kind_nxt  = kind_r;
    ins_nxt   = ins_r;
    adr_nxt   = adr_r;
    val_nxt   = val_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    araw_nxt  = araw_r;
    arec_nxt  = arec_r;
    aidx_nxt  = aidx_r;
    t_nxt     = t_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    pc_nxt    = pc_r;
    zf_nxt    = zf_r;
    sf_nxt    = sf_r;
    of_nxt    = of_r;
    err_nxt   = err_r;
    ostb_nxt  = 1'b0;
    opc_nxt   = opc_r;
    ord_nxt   = ord_r;
    oz_nxt    = oz_r;
    os_nxt    = os_r;
    oo_nxt    = oo_r;
    oe_nxt    = oe_r;
    rf_we     = 1'b0;
    rf_wa     = dsel;
    rf_wd     = '0;
    rf_ra     = dsel;
    dm_we     = 1'b0;
    dm_wd     = a_r;
    dm_ra     = aidx_r;
    st_we     = 1'b0;
    st_wa     = cnt_r[SIW-1:0];
    st_wd     = a_r;
    st_ra     = cnt_dec[SIW-1:0];
    md_req.go  = 1'b0;
    md_req.mul = 1'b0;
    md_a       = a_r;
    md_b       = rf_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          pc_nxt = cfg_wdata;
        end
        if (start) begin
          kind_nxt  = in_kind;
          ins_nxt   = in_instruction;
          adr_nxt   = in_address;
          val_nxt   = in_value;
          err_nxt   = tie_pkg::ERR_NONE;
          state_nxt = (in_kind == tie_pkg::KIND_EXEC) ? S_RDA : S_HOST;
        end
      end
      // host accesses (memory and register writes, register reads)
      S_HOST: begin
        unique case (kind_r)
          tie_pkg::KIND_WR_MEM: begin
            araw_nxt  = {22'd0, adr_r};
            ret_nxt   = S_H1WR;
            state_nxt = S_ADDR;
          end
          tie_pkg::KIND_WR_REG: begin
            rf_we     = 1'b1;
            rf_wa     = adr_r[RW-1:0];
            rf_wd     = val_r;
            state_nxt = S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_H1WR: begin
        dm_we     = 1'b1;
        dm_wd     = val_r;
        state_nxt = S_FIN;
      end
      // first operand read
      S_RDA: begin
        if (op == tie_pkg::OP_CMP || op == tie_pkg::OP_ST || op == tie_pkg::OP_PUSH) begin
          rf_ra = dsel;
        end else if (op == tie_pkg::OP_LEA) begin
          rf_ra = s1f[4 +: RW];
        end else begin
          rf_ra = s1f[RW-1:0];
        end
        state_nxt = S_RDB;
      end
      // second operand read
      S_RDB: begin
        a_nxt     = rf_rdata;
        rf_ra     = (op == tie_pkg::OP_CMP) ? s1f[RW-1:0] : s2f[RW-1:0];
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        b_nxt     = rf_rdata;
        state_nxt = S_FIN;
        unique case (op)
          tie_pkg::OP_ADD: begin
            rf_we  = 1'b1;
            rf_wd  = add_w[31:0];
            zf_nxt = add_w[31:0] == '0;
            sf_nxt = 1'b0;
            of_nxt = add_w[32];
          end
          tie_pkg::OP_SUB: begin
            rf_we  = 1'b1;
            rf_wd  = lt_w ? (rf_rdata - a_r) : (a_r - rf_rdata);
            zf_nxt = a_r == rf_rdata;
            sf_nxt = lt_w;
            of_nxt = 1'b0;
          end
          tie_pkg::OP_MUL: begin
            md_req.go  = 1'b1;
            md_req.mul = 1'b1;
            state_nxt  = S_MDWT;
          end
          tie_pkg::OP_DIV, tie_pkg::OP_MOD: begin
            if (rf_rdata == '0) begin
              err_nxt = tie_pkg::ERR_DIV0;
            end else begin
              md_req.go = 1'b1;
              state_nxt = S_MDWT;
            end
          end
          tie_pkg::OP_LD: begin
            araw_nxt  = {16'd0, ins_r[15:0]};
            ret_nxt   = S_LDRD;
            state_nxt = S_ADDR;
          end
          tie_pkg::OP_ST: begin
            araw_nxt  = {16'd0, ins_r[15:0]};
            ret_nxt   = S_STWR;
            state_nxt = S_ADDR;
          end
          tie_pkg::OP_PUSH: begin
            if (cnt_r < CW'(STACK_DEPTH)) begin
              st_we   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              err_nxt = tie_pkg::ERR_FULL;
            end
          end
          tie_pkg::OP_POP: begin
            if (cnt_r == '0) begin
              err_nxt = tie_pkg::ERR_EMPTY;
            end else begin
              cnt_nxt   = cnt_dec;
              state_nxt = S_POPW;
            end
          end
          tie_pkg::OP_LEA: begin
            araw_nxt  = a_r + {28'd0, s2f[7:4]};
            ret_nxt   = S_LEA0;
            state_nxt = S_ADDR;
          end
          tie_pkg::OP_CMP: begin
            if (a_r == rf_rdata) begin
              zf_nxt = 1'b1;
            end else begin
              zf_nxt = 1'b0;
              sf_nxt = sf_r | lt_w;
            end
          end
          default: ;
        endcase
      end
      S_MDWT: begin
        md_a = a_r;
        md_b = b_r;
        if (md_rsp.done) begin
          rf_we     = 1'b1;
          rf_wd     = md_res;
          zf_nxt    = md_res == '0;
          sf_nxt    = 1'b0;
          of_nxt    = (op == tie_pkg::OP_MUL) && md_rsp.ov;
          state_nxt = S_FIN;
        end
      end
      // reduce a data address modulo DATA_WORDS
      S_ADDR: begin
        if (POW2) begin
          aidx_nxt  = araw_r[AW-1:0];
          state_nxt = ret_r;
        end else begin
          arec_nxt  = {33'd0, araw_r} * {32'd0, AREC};
          state_nxt = S_AMWT;
        end
      end
      S_AMWT: begin
        aidx_nxt  = arem_w[AW-1:0];
        state_nxt = ret_r;
      end
      S_LDRD: state_nxt = S_LDW;
      S_LDW: begin
        rf_we     = 1'b1;
        rf_wd     = dm_rdata;
        state_nxt = S_FIN;
      end
      S_STWR: begin
        dm_we     = 1'b1;
        state_nxt = S_FIN;
      end
      // pop: write popped word, clear vacated entry
      S_POPW: begin
        rf_we     = 1'b1;
        rf_wd     = st_rdata;
        st_we     = 1'b1;
        st_wd     = '0;
        state_nxt = S_FIN;
      end
      S_LEA0: state_nxt = S_LEA1;
      S_LEA1: begin
        t_nxt     = dm_rdata;
        rf_we     = 1'b1;
        rf_wd     = dm_rdata;
        state_nxt = (s2f[3:0] == 4'd0) ? S_FIN : S_LEA2;
      end
      S_LEA2: begin
        rf_ra     = s1f[RW-1:0];
        state_nxt = S_LEA3;
      end
      S_LEA3: begin
        araw_nxt  = rf_rdata;
        ret_nxt   = S_LEA3R;
        state_nxt = S_ADDR;
      end
      S_LEA3R: state_nxt = S_LEA4;
      S_LEA4: begin
        prod_nxt  = dm_rdata * {28'd0, s2f[3:0]};
        state_nxt = S_LEA5;
      end
      S_LEA5: begin
        rf_we     = 1'b1;
        rf_wd     = t_r + prod_r;
        state_nxt = S_FIN;
      end
      // final register read and PC update
      S_FIN: begin
        rf_ra = (kind_r == tie_pkg::KIND_EXEC) ? dsel : adr_r[RW-1:0];
        if (kind_r == tie_pkg::KIND_EXEC) begin
          pc_nxt = taken ? ins_r[15:0] : pc_r + 16'd1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ostb_nxt  = 1'b1;
        opc_nxt   = pc_r;
        ord_nxt   = (kind_r == tie_pkg::KIND_WR_MEM) ? '0 : rf_rdata;
        oz_nxt    = zf_r;
        os_nxt    = sf_r;
        oo_nxt    = of_r;
        oe_nxt    = err_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pc_r    <= tie_pkg::START_PC_RST;
      zf_r    <= 1'b0;
      sf_r    <= 1'b0;
      of_r    <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pc_r    <= pc_nxt;
      zf_r    <= zf_nxt;
      sf_r    <= sf_nxt;
      of_r    <= of_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ret_r  <= ret_nxt;
    kind_r <= kind_nxt;
    ins_r  <= ins_nxt;
    adr_r  <= adr_nxt;
    val_r  <= val_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    araw_r <= araw_nxt;
    arec_r <= arec_nxt;
    aidx_r <= aidx_nxt;
    t_r    <= t_nxt;
    prod_r <= prod_nxt;
    err_r  <= err_nxt;
    opc_r  <= opc_nxt;
    ord_r  <= ord_nxt;
    oz_r   <= oz_nxt;
    os_r   <= os_nxt;
    oo_r   <= oo_nxt;
    oe_r   <= oe_nxt;
  end

  tie_rstmem #(.DEPTH(tie_pkg::REG_COUNT)) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (rf_we),
    .waddr (rf_wa),
    .wdata (rf_wd),
    .raddr (rf_ra),
    .rdata (rf_rdata)
  );

  tie_rstmem #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (st_we),
    .waddr (st_wa),
    .wdata (st_wd),
    .raddr (st_ra),
    .rdata (st_rdata)
  );

  tie_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (aidx_r),
    .wdata (dm_wd),
    .raddr (dm_ra),
    .rdata (dm_rdata)
  );

  tie_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .op_a  (md_a),
    .op_b  (md_b),
    .rsp   (md_rsp),
    .res_x (md_x),
    .res_z (md_z)
  );

  assign busy              = state_r != S_IDLE;
  assign out_strobe        = ostb_r;
  assign out_next_pc       = opc_r;
  assign out_read_data     = ord_r;
  assign out_zero_flag     = oz_r;
  assign out_sign_flag     = os_r;
  assign out_overflow_flag = oo_r;
  assign out_error_code    = oe_r;

`include "toy_isa_execute_unit_defines.svh"

  `TIE_ASSERT_NEXT(a_strobe_single, ostb_r, !ostb_r, "result strobe held two cycles")
  `TIE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
  `TIE_ASSERT_IMP(a_stack_bound, 1'b1, cnt_r <= CW'(STACK_DEPTH), "stack count past depth")
  `TIE_ASSERT_IMP(a_md_done_wait, md_rsp.done, state_r == S_MDWT, "multiply/divide done unseen")

endmodule
`default_nettype wire

// ===== test/toy_isa_execute_unit_checker.sv =====
`timescale 1ns / 1ps
// Watches the command and result channels, keeps a shadow copy of the
// execute unit's state and checks every result transaction in order.
module toy_isa_execute_unit_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_instruction,
  input  wire logic [9:0]  in_address,
  input  wire logic [31:0] in_value,
  input  wire logic        out_strobe,
  input  wire logic [15:0] out_next_pc,
  input  wire logic [31:0] out_read_data,
  input  wire logic        out_zero_flag,
  input  wire logic        out_sign_flag,
  input  wire logic        out_overflow_flag,
  input  wire logic [1:0]  out_error_code,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [15:0] next_pc;
    logic [31:0] read_data;
    logic        zf;
    logic        sf;
    logic        of;
    logic [1:0]  err;
  } exec_result_t;

  // shadow architectural state
  logic [31:0] regs [tie_pkg::REG_COUNT];
  logic [31:0] dmem [tie_pkg::DATA_WORDS_DEF];
  logic [31:0] stk [tie_pkg::STACK_DEPTH_DEF];
  int          sp;
  logic [15:0] pc;
  logic        zf, sf, of;

  exec_result_t results_due [$];

  initial fail_count = 0;
  assign pending_count = results_due.size();

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  // one bit per step shift-and-add, carry out of any accumulation counts
  function automatic logic [32:0] mul_with_carry(logic [31:0] a, logic [31:0] b);
    logic [31:0] acc, m, q;
    logic [32:0] s;
    logic        ov;
    acc = 0; m = a; q = b; ov = 0;
    while (q != 0) begin
      if (q[0]) begin
        s = {1'b0, acc} + {1'b0, m};
        ov = ov | s[32];
        acc = s[31:0];
      end
      m = m << 1;
      q = q >> 1;
    end
    return {ov, acc};
  endfunction

  // execute one transaction against the shadow state
  task automatic predict_item(logic [1:0] kind, logic [31:0] ins, logic [9:0] adr,
                              logic [31:0] val, output exec_result_t res);
    logic [7:0]  op;
    logic [2:0]  d, ra, rb, base, idx;
    logic [31:0] a, b, r, x, y;
    logic [32:0] wide;
    logic [1:0]  err;
    logic        taken;
    logic [9:0]  ma;
    op = ins[31:24]; d = ins[18:16]; ra = ins[10:8]; rb = ins[2:0];
    a = regs[ra]; b = regs[rb]; err = tie_pkg::ERR_NONE; taken = 0;
    res.read_data = 0;
    case (kind)
      tie_pkg::KIND_EXEC: begin
        case (op)
          tie_pkg::OP_LD: regs[d] = dmem[ins[9:0]];
          tie_pkg::OP_ST: dmem[ins[9:0]] = regs[d];
          tie_pkg::OP_ADD: begin
            wide = {1'b0, a} + {1'b0, b};
            regs[d] = wide[31:0];
            zf = (wide[31:0] == 0); sf = 0; of = wide[32];
          end
          tie_pkg::OP_SUB: begin
            r = (a < b) ? b - a : a - b;
            regs[d] = r;
            zf = (r == 0); sf = (a < b); of = 0;
          end
          tie_pkg::OP_MUL: begin
            wide = mul_with_carry(a, b);
            regs[d] = wide[31:0];
            zf = (wide[31:0] == 0); sf = 0; of = wide[32];
          end
          tie_pkg::OP_DIV, tie_pkg::OP_MOD: begin
            if (b == 0) begin
              err = tie_pkg::ERR_DIV0;
            end else begin
              r = (op == tie_pkg::OP_DIV) ? a / b : a % b;
              regs[d] = r;
              zf = (r == 0); sf = 0; of = 0;
            end
          end
          tie_pkg::OP_PUSH: begin
            if (sp < tie_pkg::STACK_DEPTH_DEF) begin
              stk[sp] = regs[d];
              sp++;
            end else begin
              err = tie_pkg::ERR_FULL;
            end
          end
          tie_pkg::OP_POP: begin
            if (sp == 0) begin
              err = tie_pkg::ERR_EMPTY;
            end else begin
              sp--;
              regs[d] = stk[sp];
              stk[sp] = 0;
            end
          end
          tie_pkg::OP_LEA: begin
            base = ins[14:12]; idx = ins[10:8];
            r = regs[base] + {28'd0, ins[7:4]};
            ma = r[9:0];
            regs[d] = dmem[ma];
            if (ins[3:0] != 0) begin
              ma = regs[idx][9:0];
              regs[d] = regs[d] + {28'd0, ins[3:0]} * dmem[ma];
            end
          end
          tie_pkg::OP_CMP: begin
            x = regs[d]; y = regs[ra];
            if (x == y) begin
              zf = 1;
            end else begin
              zf = 0;
              sf = sf | (x < y);
            end
          end
          tie_pkg::OP_JMP: taken = 1;
          tie_pkg::OP_JNE: taken = !zf;
          tie_pkg::OP_JE:  taken = zf;
          tie_pkg::OP_JB:  taken = sf;
          tie_pkg::OP_JA:  taken = !sf && !zf;
          default: ;
        endcase
        pc = taken ? ins[15:0] : pc + 16'd1;
        res.read_data = regs[d];
      end
      tie_pkg::KIND_WR_MEM: dmem[adr] = val;
      tie_pkg::KIND_WR_REG: begin
        regs[adr[2:0]] = val;
        res.read_data = val;
      end
      default: res.read_data = regs[adr[2:0]];
    endcase
    res.next_pc = pc; res.zf = zf; res.sf = sf; res.of = of; res.err = err;
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    exec_result_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < tie_pkg::REG_COUNT; i++) regs[i] = 0;
      for (int i = 0; i < tie_pkg::STACK_DEPTH_DEF; i++) stk[i] = 0;
      sp = 0; pc = tie_pkg::START_PC_RST; zf = 0; sf = 0; of = 0;
    end else begin
      if (out_strobe) begin
        got = '{out_next_pc, out_read_data, out_zero_flag, out_sign_flag,
                out_overflow_flag, out_error_code};
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", out_read_data, 32'd0);
        end else begin
          want = results_due.pop_front();
          if (got.next_pc !== want.next_pc)
            report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.zf !== want.zf) report_mismatch("zero_flag", 32'(got.zf), 32'(want.zf));
          if (got.sf !== want.sf) report_mismatch("sign_flag", 32'(got.sf), 32'(want.sf));
          if (got.of !== want.of)
            report_mismatch("overflow_flag", 32'(got.of), 32'(want.of));
          if (got.err !== want.err)
            report_mismatch("error_code", 32'(got.err), 32'(want.err));
        end
      end
      if (cfg_we) pc = cfg_wdata;
      if (start && !busy) begin
        predict_item(in_kind, in_instruction, in_address, in_value, want);
        results_due.push_back(want);
      end
    end
  end
endmodule

// ===== test/toy_isa_execute_unit_test.sv =====
`timescale 1ns / 1ps
module toy_isa_execute_unit_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PER_PHASE = 150;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic [1:0]  in_kind = tie_pkg::KIND_RD_REG;
  logic [31:0] in_instruction = 0;
  logic [9:0]  in_address = 0;
  logic [31:0] in_value = 0;
  logic        cfg_we = 0;
  logic [15:0] cfg_wdata = 0;
  logic        busy, out_strobe, out_zero_flag, out_sign_flag, out_overflow_flag;
  logic [15:0] out_next_pc;
  logic [31:0] out_read_data;
  logic [1:0]  out_error_code;
  int          fail_count, pending_count;
  int          cycles = 0;
  bit          idle_on = 1;

  toy_isa_execute_unit dut (.*);
  toy_isa_execute_unit_checker checker_i (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // issue one transaction and hold it until the block takes it
  task automatic send(logic [1:0] kind, logic [31:0] ins, logic [9:0] adr, logic [31:0] val);
    bit was_busy;
    start <= 1; in_kind <= kind; in_instruction <= ins; in_address <= adr; in_value <= val;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      3: return 32'h8000_0000 | $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    logic [7:0] ops [16] = '{tie_pkg::OP_LD, tie_pkg::OP_ST, tie_pkg::OP_ADD, tie_pkg::OP_SUB,
                             tie_pkg::OP_MUL, tie_pkg::OP_DIV, tie_pkg::OP_MOD,
                             tie_pkg::OP_PUSH, tie_pkg::OP_POP, tie_pkg::OP_LEA,
                             tie_pkg::OP_JMP, tie_pkg::OP_JNE, tie_pkg::OP_JE,
                             tie_pkg::OP_JB, tie_pkg::OP_JA, tie_pkg::OP_CMP};
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return ops[$urandom_range(0, 15)];
  endfunction

  task automatic random_item();
    case ($urandom_range(0, 9))
      0: send(tie_pkg::KIND_WR_MEM, $urandom, 10'($urandom_range(0, 1023)), pick_word());
      1, 2: send(tie_pkg::KIND_WR_REG, $urandom, 10'($urandom_range(0, 1023)), pick_word());
      3: send(tie_pkg::KIND_RD_REG, $urandom, 10'($urandom_range(0, 1023)), $urandom);
      default: send(tie_pkg::KIND_EXEC, {pick_opcode(), 24'($urandom)},
                    10'($urandom_range(0, 1023)), $urandom);
    endcase
  endtask

  // drain, let the block settle, then load a new start PC
  task automatic set_start_pc(logic [15:0] v);
    start <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    logic [15:0] pcs [4];
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // every data word gets written so no read ever hits an unwritten entry
    for (int i = 0; i < tie_pkg::DATA_WORDS_DEF; i++)
      send(tie_pkg::KIND_WR_MEM, $urandom, 10'(i), pick_word());

    // directed corner cases
    send(tie_pkg::KIND_WR_REG, 0, 0, 32'hFFFF_FFFF);
    send(tie_pkg::KIND_WR_REG, 0, 1, 32'h0000_0001);
    send(tie_pkg::KIND_WR_REG, 0, 2, 0);
    send(tie_pkg::KIND_WR_REG, 0, 3, 32'h8000_0000);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_ADD, 8'd4, 8'd0, 8'd1}, 0, 0);  // carry out, zero
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_SUB, 8'd5, 8'd1, 8'd0}, 0, 0);  // a < b
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_MUL, 8'd6, 8'd3, 8'd0}, 0, 0);  // carry in accumulation
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_DIV, 8'd6, 8'd0, 8'd2}, 0, 0);  // divide by zero
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_MOD, 8'd6, 8'd0, 8'd3}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_DIV, 8'd6, 8'd0, 8'd3}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_POP, 8'd7, 8'd0, 8'd0}, 0, 0);  // stack empty
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_PUSH, 8'd0, 8'd0, 8'd0}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_POP, 8'd7, 8'd0, 8'd0}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_CMP, 8'd1, 8'd1, 8'd0}, 0, 0);  // equal
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_JE, 8'd0, 16'hFFFF}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_CMP, 8'd2, 8'd1, 8'd0}, 0, 0);  // less, sign sticks
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_JB, 8'd0, 16'h1234}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_JA, 8'd0, 16'h0000}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_JNE, 8'd0, 16'h00FF}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_JMP, 8'd0, 16'hFFFF}, 0, 0);    // PC wraps next
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_ST, 8'd3, 16'hFFFF}, 0, 0);     // address taken modulo
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_LD, 8'd5, 16'h03FF}, 0, 0);
    send(tie_pkg::KIND_EXEC, {tie_pkg::OP_LEA, 8'd4, 8'h34, 8'hF3}, 0, 0); // index equals dest
    send(tie_pkg::KIND_EXEC, {8'hFF, 24'hFFFFFF}, 0, 0);                  // unknown opcode
    send(tie_pkg::KIND_RD_REG, 0, 10'h3FF, 32'hFFFF_FFFF);

    // random phases, each under its own start PC
    pcs = '{16'hFFFF, 16'h0000, 16'($urandom), tie_pkg::START_PC_RST};
    for (int p = 0; p < 4; p++) begin
      set_start_pc(pcs[p]);
      idle_on = (p != 3);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) random_item();
    end

    start <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
